/* hdl/sdof_newmark_peak_response_macros.svh */
// ----------------------------------------------------------------------------
// SDOF Newmark peak response assertion macros
// Shorthand for the clocked, reset-qualified assertions of the checker.
// ----------------------------------------------------------------------------
`ifndef SDOF_NEWMARK_PEAK_RESPONSE_MACROS_SVH
`define SDOF_NEWMARK_PEAK_RESPONSE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SDOFNM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SDOFNM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/sdofnm_pkg.sv */
// ----------------------------------------------------------------------------
// SDOF Newmark package
// Types, constants and helper functions shared by the oscillator modules.
// ----------------------------------------------------------------------------
package sdofnm_pkg;

  localparam int unsigned DataW    = 48;  // state and coefficient width
  localparam int unsigned SumW     = 50;  // accumulator for up to three terms
  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxLsb = 3;  // registers sit at 8-byte strides
  localparam int unsigned NumOps   = 9;   // multiply steps per sample
  localparam int unsigned OpW      = 4;

  localparam logic signed [DataW-1:0] SatMax = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [DataW-1:0] SatMin = 48'sh8000_0000_0000;
  localparam logic signed [SumW-1:0]  SumMax = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [SumW-1:0]  SumMin = 50'sh3_8000_0000_0000;

  typedef struct packed {
    logic signed [31:0] ground_accel;
    logic               last_sample;
  } in_word_t;

  typedef struct packed {
    logic [DataW-1:0] peak_disp;
    logic [DataW-1:0] peak_vel;
    logic [DataW-1:0] peak_accel;
  } out_word_t;

  typedef struct packed {
    logic [31:0]      time_step;
    logic [DataW-1:0] damping_coeff;
    logic [DataW-1:0] stiffness_coeff;
    logic [31:0]      denominator_recip;
  } cfg_t;

  typedef enum logic [1:0] {
    RegTimeStep,
    RegDamping,
    RegStiffness,
    RegRecip
  } cfg_reg_e;

  // Right shift applied to the rounded product.
  typedef enum logic [1:0] {
    Shift24,
    Shift32,
    Shift33,
    Shift34
  } shift_e;

  typedef enum logic [2:0] {
    XTimeStep,
    XAccel,
    XVel,
    XVelPred,
    XDispPred,
    XForce
  } xsel_e;

  typedef enum logic [2:0] {
    YTimeStep,
    YTimeStepSq,
    YDamping,
    YStiffness,
    YRecip
  } ysel_e;

  typedef enum logic [2:0] {
    BZero,
    BVel,
    BDisp,
    BGround,
    BVelPred,
    BDispPred
  } base_e;

  typedef enum logic [2:0] {
    DNone,
    DTimeStepSq,
    DVelPred,
    DDispPred,
    DForce,
    DAccel,
    DVel,
    DDisp
  } dest_e;

  typedef enum logic [1:0] {
    StIdle,
    StMulStart,
    StMulWait,
    StPeak
  } ctrl_e;

  typedef struct packed {
    xsel_e  xsel;
    ysel_e  ysel;
    shift_e shift;
    base_e  base;
    dest_e  dest;
    logic   negate;  // subtract the product instead of adding it
    logic   first;   // load the accumulator base before this product
    logic   last;    // store the saturated sum after this product
  } op_t;

  typedef struct packed {
    logic accept;
    logic mul_start;
    logic acc_en;
    logic peak_upd;
    logic finish;
  } ctl_t;

  // Micro-program of one Newmark step.
  function automatic op_t op_desc(input logic [OpW-1:0] op);
    op_t d;
    case (op)
      4'd0: d = '{xsel: XTimeStep, ysel: YTimeStep, shift: Shift32, base: BZero,
                  dest: DTimeStepSq, negate: 1'b0, first: 1'b1, last: 1'b1};
      4'd1: d = '{xsel: XAccel, ysel: YTimeStep, shift: Shift33, base: BVel,
                  dest: DVelPred, negate: 1'b0, first: 1'b1, last: 1'b1};
      4'd2: d = '{xsel: XVel, ysel: YTimeStep, shift: Shift32, base: BDisp,
                  dest: DNone, negate: 1'b0, first: 1'b1, last: 1'b0};
      4'd3: d = '{xsel: XAccel, ysel: YTimeStepSq, shift: Shift34, base: BDisp,
                  dest: DDispPred, negate: 1'b0, first: 1'b0, last: 1'b1};
      4'd4: d = '{xsel: XVelPred, ysel: YDamping, shift: Shift24, base: BGround,
                  dest: DNone, negate: 1'b0, first: 1'b1, last: 1'b0};
      4'd5: d = '{xsel: XDispPred, ysel: YStiffness, shift: Shift24, base: BGround,
                  dest: DForce, negate: 1'b0, first: 1'b0, last: 1'b1};
      4'd6: d = '{xsel: XForce, ysel: YRecip, shift: Shift32, base: BZero,
                  dest: DAccel, negate: 1'b1, first: 1'b1, last: 1'b1};
      4'd7: d = '{xsel: XAccel, ysel: YTimeStep, shift: Shift33, base: BVelPred,
                  dest: DVel, negate: 1'b0, first: 1'b1, last: 1'b1};
      4'd8: d = '{xsel: XAccel, ysel: YTimeStepSq, shift: Shift34, base: BDispPred,
                  dest: DDisp, negate: 1'b0, first: 1'b1, last: 1'b1};
      default: d = '{xsel: XTimeStep, ysel: YTimeStep, shift: Shift32, base: BZero,
                     dest: DNone, negate: 1'b0, first: 1'b0, last: 1'b0};
    endcase
    return d;
  endfunction

  function automatic logic [DataW-1:0] mag48(input logic signed [DataW-1:0] x);
    logic [DataW-1:0] u;
    u = x;
    return u[DataW-1] ? (~u + 48'd1) : u;
  endfunction

  function automatic logic signed [DataW-1:0] sat48(input logic signed [SumW-1:0] s);
    logic signed [DataW-1:0] r;
    if (s > SumMax) begin
      r = SatMax;
    end else if (s < SumMin) begin
      r = SatMin;
    end else begin
      r = s[DataW-1:0];
    end
    return r;
  endfunction

endpackage

/* hdl/sdof_newmark_peak_response.sv */
// ----------------------------------------------------------------------------
// SDOF Newmark peak response
// Damped single-degree-of-freedom oscillator stepped by the Newmark
// average-acceleration method, with running peaks of |u|, |v| and |a|.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                    Word
//   -------  ---------  ---------------------------  --------------------------
//   in       input      in_valid_i / in_stall_o      ground_accel, last_sample
//   out      output     out_valid_o / out_stall_i    peak_disp/vel/accel
//   cfg      input      psel, penable, pwrite/pready time step and coefficients
//
// A word is taken only while the sequencer is idle. After it is accepted,
// in_stall_o stays high for nine multiply steps on the one shared 24x24
// multiplier and the peak update; no new word is taken before it is done.
// A word marked last holds the peak cycle until the output register is free.
// Reset clears the oscillator state, the peaks and the output register, and
// loads the register defaults; there is no clearing pass.
// A stalled output word sits in its register while the next input word is
// already being worked on.
//
module sdof_newmark_peak_response (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  sdofnm_pkg::in_word_t              in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output sdofnm_pkg::out_word_t             out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sdofnm_pkg::CfgAddrW-1:0]   paddr,
  input  logic [sdofnm_pkg::CfgDataW-1:0]   pwdata,
  output logic [sdofnm_pkg::CfgDataW-1:0]   prdata,
  output logic                              pready
);
  import sdofnm_pkg::*;

  cfg_t           cfg;
  ctl_t           ctl;
  logic [OpW-1:0] op;
  op_t            desc;

  // Multiplier operands and result.
  logic signed [DataW-1:0] mul_x;
  logic        [DataW-1:0] mul_y, mul_mag;
  logic                    mul_done, mul_neg;

  // Oscillator state (signed Q16.32) and step temporaries.
  logic signed [DataW-1:0] u_q, v_q, a_q, vp_q, up_q, num_q, sat_new;
  logic        [31:0]      dt2_q;
  logic signed [31:0]      g_q;
  logic                    last_q;

  // Accumulator for the sums of each Newmark equation.
  logic signed [SumW-1:0]  sum_q, base, term, mag_ext, sum_new;

  // Peak tracking and output register.
  logic [DataW-1:0] disp_pk_q, vel_pk_q, accel_pk_q;
  logic [DataW-1:0] mag_u, mag_v, mag_a;
  out_word_t        new_pk, out_q;
  logic             out_valid_q, out_free;

  sdofnm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sdofnm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mul_done_i (mul_done),
    .last_i     (last_q),
    .out_free_i (out_free),
    .in_stall_o (in_stall_o),
    .op_o       (op),
    .ctl_o      (ctl)
  );

  sdofnm_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl.mul_start),
    .x_i     (mul_x),
    .y_i     (mul_y),
    .shift_i (desc.shift),
    .done_o  (mul_done),
    .mag_o   (mul_mag),
    .neg_o   (mul_neg)
  );

  // The current step of the program picks operands, base and destination.
  assign desc = op_desc(op);

  always_comb begin
    case (desc.xsel)
      XTimeStep: mul_x = $signed({16'd0, cfg.time_step});
      XAccel:    mul_x = a_q;
      XVel:      mul_x = v_q;
      XVelPred:  mul_x = vp_q;
      XDispPred: mul_x = up_q;
      XForce:    mul_x = num_q;
      default:   mul_x = '0;
    endcase
  end

  always_comb begin
    case (desc.ysel)
      YTimeStep:   mul_y = {16'd0, cfg.time_step};
      YTimeStepSq: mul_y = {16'd0, dt2_q};
      YDamping:    mul_y = cfg.damping_coeff;
      YStiffness:  mul_y = cfg.stiffness_coeff;
      YRecip:      mul_y = {16'd0, cfg.denominator_recip};
      default:     mul_y = '0;
    endcase
  end

  // The ground sample is Q8.24; shifting it up by eight bits gives Q16.32.
  always_comb begin
    case (desc.base)
      BZero:     base = '0;
      BVel:      base = $signed({{2{v_q[DataW-1]}}, v_q});
      BDisp:     base = $signed({{2{u_q[DataW-1]}}, u_q});
      BGround:   base = $signed({{10{g_q[31]}}, g_q, 8'd0});
      BVelPred:  base = $signed({{2{vp_q[DataW-1]}}, vp_q});
      BDispPred: base = $signed({{2{up_q[DataW-1]}}, up_q});
      default:   base = '0;
    endcase
  end

  // The multiplier returns a clamped magnitude and the operand's sign. The
  // force step negates its product, which is why an exact -2^47 there turns
  // into +2^47 and is then clamped by the final saturation.
  assign mag_ext = $signed({2'b00, mul_mag});
  assign term    = (mul_neg ^ desc.negate) ? -mag_ext : mag_ext;
  assign sum_new = sum_q + term;
  assign sat_new = sat48(sum_new);

  // Peaks take the new state magnitudes; they are at most 2^47.
  assign mag_u = mag48(u_q);
  assign mag_v = mag48(v_q);
  assign mag_a = mag48(a_q);
  assign new_pk.peak_disp  = (mag_u > disp_pk_q)  ? mag_u : disp_pk_q;
  assign new_pk.peak_vel   = (mag_v > vel_pk_q)   ? mag_v : vel_pk_q;
  assign new_pk.peak_accel = (mag_a > accel_pk_q) ? mag_a : accel_pk_q;

  assign out_free = !out_valid_q || !out_stall_i;

  // Oscillator state and peaks. The acceleration is overwritten at the force
  // step and the velocity one step later, after their last use as operands.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_q        <= '0;
      v_q        <= '0;
      a_q        <= '0;
      disp_pk_q  <= '0;
      vel_pk_q   <= '0;
      accel_pk_q <= '0;
    end else begin
      if (ctl.acc_en && desc.last) begin
        case (desc.dest)
          DAccel:  a_q <= sat_new;
          DVel:    v_q <= sat_new;
          DDisp:   u_q <= sat_new;
          default: ;
        endcase
      end
      if (ctl.finish) begin
        // The record is done: its peaks leave through the output register.
        u_q        <= '0;
        v_q        <= '0;
        a_q        <= '0;
        disp_pk_q  <= '0;
        vel_pk_q   <= '0;
        accel_pk_q <= '0;
      end else if (ctl.peak_upd) begin
        disp_pk_q  <= new_pk.peak_disp;
        vel_pk_q   <= new_pk.peak_vel;
        accel_pk_q <= new_pk.peak_accel;
      end
    end
  end

  // Input hold register, accumulator and step temporaries.
  always_ff @(posedge clk_i) begin
    if (ctl.accept) begin
      g_q    <= in_data_i.ground_accel;
      last_q <= in_data_i.last_sample;
    end
    if (ctl.mul_start && desc.first) begin
      sum_q <= base;
    end
    if (ctl.acc_en) begin
      sum_q <= sum_new;
      if (desc.last) begin
        case (desc.dest)
          DTimeStepSq: dt2_q <= sat_new[31:0];
          DVelPred:    vp_q  <= sat_new;
          DDispPred:   up_q  <= sat_new;
          DForce:      num_q <= sat_new;
          default: ;
        endcase
      end
    end
  end

  // Output register: loaded when a record ends, freed when the word is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.finish) begin
      out_q <= new_pk;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hdl/sdofnm_cfg.sv */
// ----------------------------------------------------------------------------
// SDOF Newmark configuration registers
// APB-style register file holding the time step and derived coefficients.
// ----------------------------------------------------------------------------
module sdofnm_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sdofnm_pkg::CfgAddrW-1:0]   paddr,
  input  logic [sdofnm_pkg::CfgDataW-1:0]   pwdata,
  output logic [sdofnm_pkg::CfgDataW-1:0]   prdata,
  output logic                              pready,
  output sdofnm_pkg::cfg_t                  cfg_o
);
  import sdofnm_pkg::*;

  cfg_t     cfg_q;
  cfg_reg_e idx;
  logic     wr_en;

  assign idx    = cfg_reg_e'(paddr[CfgAddrW-1:CfgIdxLsb]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_step         <= '0;
      cfg_q.damping_coeff     <= '0;
      cfg_q.stiffness_coeff   <= '0;
      cfg_q.denominator_recip <= '1;
    end else if (wr_en) begin
      case (idx)
        RegTimeStep:  cfg_q.time_step         <= pwdata[31:0];
        RegDamping:   cfg_q.damping_coeff     <= pwdata[DataW-1:0];
        RegStiffness: cfg_q.stiffness_coeff   <= pwdata[DataW-1:0];
        RegRecip:     cfg_q.denominator_recip <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegTimeStep:  prdata = {32'd0, cfg_q.time_step};
      RegDamping:   prdata = {16'd0, cfg_q.damping_coeff};
      RegStiffness: prdata = {16'd0, cfg_q.stiffness_coeff};
      RegRecip:     prdata = {32'd0, cfg_q.denominator_recip};
      default:      prdata = '0;
    endcase
  end

endmodule

/* hdl/sdofnm_mul.sv */
// ----------------------------------------------------------------------------
// SDOF Newmark shared multiplier
// Signed 48 by unsigned 48 bit multiply built from four 24x24 partial
// products, followed by round-half-away-from-zero, right shift and saturation.
// ----------------------------------------------------------------------------
module sdofnm_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [sdofnm_pkg::DataW-1:0] x_i,
  input  logic        [sdofnm_pkg::DataW-1:0] y_i,
  input  sdofnm_pkg::shift_e                  shift_i,
  output logic                                done_o,
  output logic        [sdofnm_pkg::DataW-1:0] mag_o,
  output logic                                neg_o
);
  import sdofnm_pkg::*;

  localparam int unsigned HalfW = DataW / 2;
  localparam int unsigned AccW  = 2 * DataW;
  localparam int unsigned RndW  = AccW - 24;
  localparam logic [2:0]  CntLastPp = 3'd3;
  localparam logic [2:0]  CntRound  = 3'd5;

  logic             busy_q, pv_q, done_q, neg_q;
  logic [2:0]       cnt_q;
  logic [1:0]       psh_q, psh;
  logic [DataW-1:0] xm_q, y_q, prod_q, res_q, res_d, pp, limit;
  logic [HalfW-1:0] a_h, b_h;
  logic [AccW-1:0]  acc_q, half, addend;
  logic [RndW-1:0]  rnd;
  shift_e           sh_q;

  // Partial product selection: the counter walks low/high halves of each side.
  assign a_h = cnt_q[1] ? xm_q[DataW-1:HalfW] : xm_q[HalfW-1:0];
  assign b_h = cnt_q[0] ? y_q[DataW-1:HalfW] : y_q[HalfW-1:0];
  assign pp  = a_h * b_h;
  assign psh = {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};

  always_comb begin
    case (shift_i)
      Shift24: half = AccW'(1) << 23;
      Shift32: half = AccW'(1) << 31;
      Shift33: half = AccW'(1) << 32;
      Shift34: half = AccW'(1) << 33;
      default: half = '0;
    endcase
  end

  always_comb begin
    case (psh_q)
      2'd0:    addend = {48'd0, prod_q};
      2'd1:    addend = {24'd0, prod_q, 24'd0};
      2'd2:    addend = {prod_q, 48'd0};
      default: addend = '0;
    endcase
  end

  // Rounding bias is preloaded into the accumulator, so only the shift and
  // the clamp remain here.
  always_comb begin
    case (sh_q)
      Shift24: rnd = acc_q[AccW-1:24];
      Shift32: rnd = {8'd0, acc_q[AccW-1:32]};
      Shift33: rnd = {9'd0, acc_q[AccW-1:33]};
      Shift34: rnd = {10'd0, acc_q[AccW-1:34]};
      default: rnd = '0;
    endcase
    limit = neg_q ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    if ((rnd[RndW-1:DataW] != '0) || (rnd[DataW-1:0] > limit)) begin
      res_d = limit;
    end else begin
      res_d = rnd[DataW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      pv_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      pv_q   <= !start_i && busy_q && (cnt_q <= CntLastPp);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == CntRound) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      xm_q  <= mag48(x_i);
      neg_q <= x_i[DataW-1];
      y_q   <= y_i;
      sh_q  <= shift_i;
      acc_q <= half;
    end else begin
      if (busy_q && (cnt_q <= CntLastPp)) begin
        prod_q <= pp;
        psh_q  <= psh;
      end
      if (pv_q) begin
        acc_q <= acc_q + addend;
      end
      if (busy_q && (cnt_q == CntRound)) begin
        res_q <= res_d;
      end
    end
  end

  assign done_o = done_q;
  assign mag_o  = res_q;
  assign neg_o  = neg_q;

endmodule

/* hdl/sdofnm_ctrl.sv */
// ----------------------------------------------------------------------------
// SDOF Newmark sequencer
// Steps through the multiply program of one sample and the peak update.
// ----------------------------------------------------------------------------
module sdofnm_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        mul_done_i,
  input  logic                        last_i,
  input  logic                        out_free_i,
  output logic                        in_stall_o,
  output logic [sdofnm_pkg::OpW-1:0]  op_o,
  output sdofnm_pkg::ctl_t            ctl_o
);
  import sdofnm_pkg::*;

  localparam logic [OpW-1:0] LastOp = OpW'(NumOps - 1);

  ctrl_e          state_q, state_d;
  logic [OpW-1:0] op_q, op_d;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StMulStart;
          op_d    = '0;
        end
      end
      StMulStart: state_d = StMulWait;
      StMulWait: begin
        if (mul_done_i) begin
          if (op_q == LastOp) begin
            state_d = StPeak;
          end else begin
            op_d    = op_q + 1'b1;
            state_d = StMulStart;
          end
        end
      end
      StPeak: begin
        if (!last_i || out_free_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    ctl_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      StIdle: begin
        in_stall_o   = 1'b0;
        ctl_o.accept = in_valid_i;
      end
      StMulStart: ctl_o.mul_start = 1'b1;
      StMulWait:  ctl_o.acc_en = mul_done_i;
      StPeak: begin
        ctl_o.peak_upd = 1'b1;
        ctl_o.finish   = last_i && out_free_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      op_q    <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  assign op_o = op_q;

endmodule

/* hdl/sdofnm_checker.sv */
// ----------------------------------------------------------------------------
// SDOF Newmark port checker
// Watches the top-level ports for busy, result and handshake behavior.
// ----------------------------------------------------------------------------
`include "sdof_newmark_peak_response_macros.svh"

module sdofnm_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input sdofnm_pkg::out_word_t out_data_o
);
  import sdofnm_pkg::*;

  localparam logic [DataW-1:0] PeakLimit = 48'h8000_0000_0000;

  logic in_take;
  logic out_held;
  logic peaks_ok;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_held = out_valid_o && out_stall_i;
  assign peaks_ok = (out_data_o.peak_disp <= PeakLimit) &&
                    (out_data_o.peak_vel <= PeakLimit) &&
                    (out_data_o.peak_accel <= PeakLimit);

  // An accepted word keeps the block busy on the following cycle.
  `SDOFNM_ASSERT_NXT(a_busy_after_accept, in_take, in_stall_o, "busy missing after accept")

  // A result only appears at the end of a word's processing.
  `SDOFNM_ASSERT_IMP(a_result_from_work, $rose(out_valid_o), $past(in_stall_o), "stray result")

  // Saturated state keeps every peak magnitude at or below 2^47.
  `SDOFNM_ASSERT_IMP(a_peak_range, out_valid_o, peaks_ok, "peak beyond saturation limit")

  // A stalled result word holds.
  `SDOFNM_ASSERT_NXT(a_out_hold, out_held, out_valid_o && $stable(out_data_o), "held word changed")

endmodule

bind sdof_newmark_peak_response sdofnm_checker u_sdofnm_checker (.*);
